/* sv/mrt_pkg.sv */
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared types and codes of the memory residency table.
// ----------------------------------------------------------------------------
package mrt_pkg;

    localparam int ID_W    = 16;
    localparam int SIZE_W  = 12;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;
    localparam int FREE_W  = 17;
    localparam int TOTAL_W = 16;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 16'd1024;

    localparam logic [ADDR_W-3:0] REG_TOTAL_MEMORY = 1'b0;

    localparam logic [REQ_W-1:0] REQ_LOAD     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_EVICT    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_ADD_DISK = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RM_DISK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_FIND     = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ID_W-1:0]   proc_id;
        logic [SIZE_W-1:0] proc_size;
        logic              in_memory;
    } t_req_beat;

    typedef struct packed {
        logic               load;
        logic [TOTAL_W-1:0] total;
    } t_cfg;

    typedef struct packed {
        logic                     valid;
        logic [STAT_W-1:0]        status;
        logic signed [FREE_W-1:0] free;
    } t_result;

endpackage

/* sv/mrt_ram.sv */
// ----------------------------------------------------------------------------
// mrt_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mrt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/mrt_ctrl.sv */
// ----------------------------------------------------------------------------
// mrt_ctrl
// Request sequencer: table RAMs, newest-first search, compaction and the
// saturating free-memory counter.
// ----------------------------------------------------------------------------
module mrt_ctrl #(
    parameter int MEM_ENTRIES  = 16,
    parameter int DISK_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mrt_pkg::t_req_beat i_req,
    input  mrt_pkg::t_cfg      i_cfg,
    output mrt_pkg::t_result   o_res,
    input  logic               i_res_ready
);
    import mrt_pkg::*;

    localparam int MIW = $clog2(MEM_ENTRIES);
    localparam int DIW = $clog2(DISK_ENTRIES);
    localparam int MCW = $clog2(MEM_ENTRIES + 1);
    localparam int DCW = $clog2(DISK_ENTRIES + 1);
    localparam int XIW = (MIW > DIW) ? MIW : DIW;
    localparam int XCW = (MCW > DCW) ? MCW : DCW;
    localparam int MEM_W = ID_W + SIZE_W;

    t_state r_state, n_state;

    logic [REQ_W-1:0]  r_req, n_req;
    logic [ID_W-1:0]   r_id, n_id;
    logic [SIZE_W-1:0] r_size, n_size;
    logic              r_sel_mem, n_sel_mem;
    logic [STAT_W-1:0] r_status, n_status;

    logic [MCW-1:0] r_mem_count, n_mem_count;
    logic [DCW-1:0] r_disk_count, n_disk_count;
    logic signed [FREE_W-1:0] r_free, n_free;

    logic [XIW-1:0] r_idx, n_idx;
    logic           r_more, n_more;
    logic           r_pend, n_pend;
    logic [XIW-1:0] r_pidx, n_pidx;
    logic [XCW-1:0] r_src, n_src;
    logic           r_wpend, n_wpend;
    logic [XIW-1:0] r_wdst, n_wdst;

    logic             mem_we, disk_we;
    logic [XIW-1:0]   wptr, rptr;
    logic [MEM_W-1:0] mem_wdata, mem_rdata;
    logic [ID_W-1:0]  disk_wdata, disk_rdata;

    logic [ID_W-1:0]   rd_id;
    logic [SIZE_W-1:0] rd_size;
    logic [XCW-1:0]    sel_count;
    logic              hit, src_more, mem_full, disk_full;
    logic [XCW-1:0]    cnt_m1, src_m1, pidx_p1;

    logic                     add_en, add_neg;
    logic [SIZE_W-1:0]        add_mag;
    logic signed [FREE_W:0]   addend, sum;
    logic signed [FREE_W-1:0] sat;

    mrt_ram #(.WIDTH(MEM_W), .DEPTH(MEM_ENTRIES)) u_mem_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (wptr[MIW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (rptr[MIW-1:0]),
        .o_rdata (mem_rdata)
    );

    mrt_ram #(.WIDTH(ID_W), .DEPTH(DISK_ENTRIES)) u_disk_ram (
        .i_clk   (i_clk),
        .i_we    (disk_we),
        .i_waddr (wptr[DIW-1:0]),
        .i_wdata (disk_wdata),
        .i_raddr (rptr[DIW-1:0]),
        .o_rdata (disk_rdata)
    );

    assign rd_id     = r_sel_mem ? mem_rdata[ID_W-1:0] : disk_rdata;
    assign rd_size   = mem_rdata[MEM_W-1:ID_W];
    assign sel_count = r_sel_mem ? XCW'(r_mem_count) : XCW'(r_disk_count);
    assign hit       = r_pend && (rd_id == r_id);
    assign src_more  = r_src < sel_count;
    assign mem_full  = r_mem_count == MCW'(MEM_ENTRIES);
    assign disk_full = r_disk_count == DCW'(DISK_ENTRIES);
    assign cnt_m1    = sel_count - XCW'(1);
    assign src_m1    = r_src - XCW'(1);
    assign pidx_p1   = XCW'(r_pidx) + XCW'(1);
    assign rptr      = (r_state == S_SHIFT) ? r_src[XIW-1:0] : r_idx;

    // shared saturating adder for the free counter
    assign addend = add_neg ? -$signed({{(FREE_W+1-SIZE_W){1'b0}}, add_mag})
                            :  $signed({{(FREE_W+1-SIZE_W){1'b0}}, add_mag});
    assign sum    = {r_free[FREE_W-1], r_free} + addend;
    assign sat    = (sum[FREE_W] != sum[FREE_W-1])
                  ? {sum[FREE_W], {(FREE_W-1){~sum[FREE_W]}}}
                  : sum[FREE_W-1:0];

    assign o_ready      = r_state == S_IDLE;
    assign o_res.valid  = r_state == S_DONE;
    assign o_res.status = r_status;
    assign o_res.free   = r_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_START;
            end
            S_START: begin
                if ((r_req == REQ_EVICT || r_req == REQ_RM_DISK || r_req == REQ_FIND)
                    && sel_count != '0) begin
                    n_state = S_SEARCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_state = (r_req == REQ_FIND) ? S_DONE : S_SHIFT;
                end else if (!r_more) begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (!src_more) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_req        = r_req;
        n_id         = r_id;
        n_size       = r_size;
        n_sel_mem    = r_sel_mem;
        n_status     = r_status;
        n_mem_count  = r_mem_count;
        n_disk_count = r_disk_count;
        n_idx        = r_idx;
        n_more       = r_more;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_src        = r_src;
        n_wpend      = r_wpend;
        n_wdst       = r_wdst;
        mem_we       = 1'b0;
        disk_we      = 1'b0;
        wptr         = r_wdst;
        mem_wdata    = mem_rdata;
        disk_wdata   = disk_rdata;
        add_en       = 1'b0;
        add_neg      = 1'b0;
        add_mag      = rd_size;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req     = i_req.req_type;
                    n_id      = i_req.proc_id;
                    n_size    = i_req.proc_size;
                    n_sel_mem = (i_req.req_type == REQ_LOAD) ||
                                (i_req.req_type == REQ_EVICT) ||
                                ((i_req.req_type == REQ_FIND) && i_req.in_memory);
                end
            end
            S_START: begin
                n_status = ST_NOT_FOUND;
                n_idx    = cnt_m1[XIW-1:0];
                n_more   = 1'b1;
                n_pend   = 1'b0;
                case (r_req)
                    REQ_LOAD: begin
                        if (mem_full) begin
                            n_status = ST_FULL;
                        end else begin
                            mem_we      = 1'b1;
                            wptr        = XIW'(r_mem_count);
                            mem_wdata   = {r_size, r_id};
                            n_mem_count = r_mem_count + MCW'(1);
                            add_en      = 1'b1;
                            add_neg     = 1'b1;
                            add_mag     = r_size;
                            n_status    = ST_OK;
                        end
                    end
                    REQ_ADD_DISK: begin
                        if (disk_full) begin
                            n_status = ST_FULL;
                        end else begin
                            disk_we      = 1'b1;
                            wptr         = XIW'(r_disk_count);
                            disk_wdata   = r_id;
                            n_disk_count = r_disk_count + DCW'(1);
                            n_status     = ST_OK;
                        end
                    end
                    default: ;
                endcase
            end
            S_SEARCH: begin
                if (hit) begin
                    n_status = ST_OK;
                    n_pend   = 1'b0;
                    n_src    = pidx_p1;
                    n_wpend  = 1'b0;
                    if (r_req == REQ_EVICT) add_en = 1'b1;
                end else if (r_more) begin
                    n_pend = 1'b1;
                    n_pidx = r_idx;
                    n_more = r_idx != '0;
                    n_idx  = r_idx - XIW'(1);
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_SHIFT: begin
                if (r_wpend) begin
                    mem_we  = r_sel_mem;
                    disk_we = !r_sel_mem;
                end
                if (src_more) begin
                    n_wpend = 1'b1;
                    n_wdst  = src_m1[XIW-1:0];
                    n_src   = r_src + XCW'(1);
                end else begin
                    n_wpend = 1'b0;
                    if (r_sel_mem) n_mem_count  = r_mem_count - MCW'(1);
                    else           n_disk_count = r_disk_count - DCW'(1);
                end
            end
            default: ;
        endcase

        if (i_cfg.load) begin
            n_free = $signed({1'b0, i_cfg.total});
        end else if (add_en) begin
            n_free = sat;
        end else begin
            n_free = r_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mem_count  <= '0;
            r_disk_count <= '0;
            r_free       <= $signed({1'b0, TOTAL_RESET});
            r_pend       <= 1'b0;
            r_more       <= 1'b0;
            r_wpend      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mem_count  <= n_mem_count;
            r_disk_count <= n_disk_count;
            r_free       <= n_free;
            r_pend       <= n_pend;
            r_more       <= n_more;
            r_wpend      <= n_wpend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_id      <= n_id;
        r_size    <= n_size;
        r_sel_mem <= n_sel_mem;
        r_status  <= n_status;
        r_idx     <= n_idx;
        r_pidx    <= n_pidx;
        r_src     <= n_src;
        r_wdst    <= n_wdst;
    end

    a_mem_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mem_count <= MCW'(MEM_ENTRIES))
        else $error("memory table count out of range");

    a_disk_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disk_count <= DCW'(DISK_ENTRIES))
        else $error("disk table count out of range");

    a_probe_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && r_pend) |-> (XCW'(r_pidx) < sel_count))
        else $error("search probe beyond table fill");

    a_evict_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && n_state == S_DONE && r_sel_mem && !i_cfg.load)
        |=> (r_mem_count == $past(r_mem_count) - MCW'(1)))
        else $error("evict did not shrink memory table");

endmodule

/* sv/memory_residency_table_unit.sv */
// ----------------------------------------------------------------------------
// memory_residency_table_unit
// Process residency tables for memory and disk with a free-memory counter.
// ----------------------------------------------------------------------------
// Requests enter on the slave stream: tuser carries the request kind and the
// table select for find, tdata the process id and size. Each request returns
// exactly one result beat on the master stream: status in tuser, the signed
// free-memory counter in tdata.
// A request is taken only while the sequencer is idle. Load, disk add, an
// unknown kind and any request on an empty table need no search: they pass
// from the start state straight to the result. Evict, remove and find scan
// the selected table newest entry first, one RAM read per cycle; evict and
// remove then close the gap one entry per cycle. Each table RAM has a single
// read port, so the scan and the shift go one entry at a time.
// The result sits in an output register; the sequencer may take the next
// request while it waits, but stalls before delivering that one until the
// receiver takes the earlier beat.
// Reset empties both tables and loads the counter with total_memory (1024).
// Writing total_memory over APB reloads the counter. The user must write it
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module memory_residency_table_unit #(
    parameter int MEM_ENTRIES  = 16,
    parameter int DISK_ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [31:0]                 i_s_axis_tdata,  // proc_id, proc_size
    input  logic [3:0]                  i_s_axis_tuser,  // req_type, in_memory
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [23:0]                 o_m_axis_tdata,  // free_memory
    output logic [1:0]                  o_m_axis_tuser,  // status
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [mrt_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [mrt_pkg::DATA_W-1:0]  i_pwdata,
    output logic [mrt_pkg::DATA_W-1:0]  o_prdata,
    output logic                        o_pready
);
    import mrt_pkg::*;

    logic [TOTAL_W-1:0] r_total;
    logic               r_m_valid;
    logic [STAT_W-1:0]  r_m_status;
    logic [FREE_W-1:0]  r_m_free;

    logic      cfg_hit, cfg_wr, res_ready;
    t_cfg      cfg;
    t_req_beat req;
    t_result   res;

    assign cfg_hit = i_paddr[ADDR_W-1:2] == REG_TOTAL_MEMORY;
    assign cfg_wr  = i_psel && i_penable && i_pwrite && cfg_hit;

    assign cfg.load  = cfg_wr;
    assign cfg.total = i_pwdata[TOTAL_W-1:0];

    assign req.req_type  = i_s_axis_tuser[REQ_W-1:0];
    assign req.in_memory = i_s_axis_tuser[REQ_W];
    assign req.proc_id   = i_s_axis_tdata[ID_W-1:0];
    assign req.proc_size = i_s_axis_tdata[ID_W+SIZE_W-1:ID_W];

    assign res_ready = !r_m_valid || i_m_axis_tready;

    mrt_ctrl #(
        .MEM_ENTRIES  (MEM_ENTRIES),
        .DISK_ENTRIES (DISK_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_req       (req),
        .i_cfg       (cfg),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= TOTAL_RESET;
            r_m_valid <= 1'b0;
        end else begin
            if (cfg_wr) r_total <= cfg.total;
            if (res_ready) r_m_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_m_status <= res.status;
            r_m_free   <= res.free;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{(24-FREE_W){1'b0}}, r_m_free};
    assign o_m_axis_tuser  = r_m_status;
    assign o_prdata        = cfg_hit ? {{(DATA_W-TOTAL_W){1'b0}}, r_total} : '0;
    assign o_pready        = 1'b1;

endmodule

/* tb/sv/mrt_residency_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrt_residency_checker
// Watches the request, result and APB channels of the residency table unit.
// ----------------------------------------------------------------------------
// Keeps its own copy of the memory table, the disk table and the free-memory
// counter, works out the status and counter of every accepted request beat,
// and compares them in order against the result beats taken on the master
// stream. Hands back the number of failures and results still owed.
// ----------------------------------------------------------------------------
module mrt_residency_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_ready,
    input  logic [31:0]                 i_req_data,   // proc_id, proc_size
    input  logic [3:0]                  i_req_user,   // req_type, in_memory
    input  logic                        i_res_valid,
    input  logic                        i_res_ready,
    input  logic [23:0]                 i_res_data,   // free_memory
    input  logic [1:0]                  i_res_user,   // status
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [mrt_pkg::ADDR_W-1:0]  i_paddr,
    input  logic [mrt_pkg::DATA_W-1:0]  i_pwdata,
    input  logic                        i_pready,
    output int                          o_pending,
    output int                          o_fail_count,
    output int                          o_result_count,
    output int                          o_full_count,
    output int                          o_miss_count
);
    import mrt_pkg::*;

    localparam int MEM_DEPTH  = 16;
    localparam int DISK_DEPTH = 16;
    localparam int FREE_TOP   = 65535;
    localparam int FREE_FLOOR = -65536;
    localparam logic [ADDR_W-1:0] TOTAL_ADDR = {REG_TOTAL_MEMORY, 2'b00};

    logic [ID_W-1:0]   mem_id_tab   [MEM_DEPTH];
    logic [SIZE_W-1:0] mem_size_tab [MEM_DEPTH];
    logic [ID_W-1:0]   disk_id_tab  [DISK_DEPTH];
    int                mem_used;
    int                disk_used;
    int                free_level;
    t_result           outcomes [$];
    int                fail_cnt;
    int                result_cnt;
    int                full_cnt;
    int                miss_cnt;

    initial begin
        o_pending      = 0;
        o_fail_count   = 0;
        o_result_count = 0;
        o_full_count   = 0;
        o_miss_count   = 0;
        fail_cnt       = 0;
        result_cnt     = 0;
        full_cnt       = 0;
        miss_cnt       = 0;
        mem_used       = 0;
        disk_used      = 0;
        free_level     = int'(TOTAL_RESET);
    end

    function automatic int clamp_level(input int v);
        if (v > FREE_TOP) return FREE_TOP;
        if (v < FREE_FLOOR) return FREE_FLOOR;
        return v;
    endfunction

    // newest-first search, -1 when absent
    function automatic int mem_lookup(input logic [ID_W-1:0] id);
        int k;
        for (k = mem_used - 1; k >= 0; k--)
            if (mem_id_tab[k] == id) return k;
        return -1;
    endfunction

    function automatic int disk_lookup(input logic [ID_W-1:0] id);
        int k;
        for (k = disk_used - 1; k >= 0; k--)
            if (disk_id_tab[k] == id) return k;
        return -1;
    endfunction

    task automatic residency_predict(input t_req_beat rq, output t_result res);
        int pos;
        int k;
        res.valid  = 1'b1;
        res.status = ST_NOT_FOUND;
        case (rq.req_type)
            REQ_LOAD: begin
                if (mem_used >= MEM_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    mem_id_tab[mem_used]   = rq.proc_id;
                    mem_size_tab[mem_used] = rq.proc_size;
                    mem_used++;
                    free_level = clamp_level(free_level - int'(rq.proc_size));
                    res.status = ST_OK;
                end
            end
            REQ_EVICT: begin
                pos = mem_lookup(rq.proc_id);
                if (pos >= 0) begin
                    free_level = clamp_level(free_level + int'(mem_size_tab[pos]));
                    for (k = pos; k < mem_used - 1; k++) begin
                        mem_id_tab[k]   = mem_id_tab[k+1];
                        mem_size_tab[k] = mem_size_tab[k+1];
                    end
                    mem_used--;
                    res.status = ST_OK;
                end
            end
            REQ_ADD_DISK: begin
                if (disk_used >= DISK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    disk_id_tab[disk_used] = rq.proc_id;
                    disk_used++;
                    res.status = ST_OK;
                end
            end
            REQ_RM_DISK: begin
                pos = disk_lookup(rq.proc_id);
                if (pos >= 0) begin
                    for (k = pos; k < disk_used - 1; k++)
                        disk_id_tab[k] = disk_id_tab[k+1];
                    disk_used--;
                    res.status = ST_OK;
                end
            end
            REQ_FIND: begin
                pos = rq.in_memory ? mem_lookup(rq.proc_id) : disk_lookup(rq.proc_id);
                if (pos >= 0) res.status = ST_OK;
            end
            default: ;
        endcase
        res.free = free_level[FREE_W-1:0];
    endtask

    always @(posedge i_clk) begin
        t_req_beat rq;
        t_result   want;
        if (!i_rst_n) begin
            mem_used   = 0;
            disk_used  = 0;
            free_level = int'(TOTAL_RESET);
            outcomes.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == TOTAL_ADDR)
                free_level = int'(i_pwdata[TOTAL_W-1:0]);
            if (i_req_valid && i_req_ready) begin
                rq.req_type  = i_req_user[REQ_W-1:0];
                rq.in_memory = i_req_user[REQ_W];
                rq.proc_id   = i_req_data[ID_W-1:0];
                rq.proc_size = i_req_data[ID_W +: SIZE_W];
                residency_predict(rq, want);
                if (want.status == ST_FULL) full_cnt++;
                if (want.status == ST_NOT_FOUND) miss_cnt++;
                outcomes.push_back(want);
            end
            if (i_res_valid && i_res_ready) begin
                if (outcomes.size() == 0) begin
                    fail_cnt++;
                    $error("result beat with no request outstanding: status %0d free %0d",
                           i_res_user, $signed(i_res_data[FREE_W-1:0]));
                end else begin
                    want = outcomes.pop_front();
                    result_cnt++;
                    if (i_res_user !== want.status) begin
                        fail_cnt++;
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_res_user);
                    end
                    if (i_res_data[FREE_W-1:0] !== want.free) begin
                        fail_cnt++;
                        $error("free_memory mismatch: expected %0d, actual %0d",
                               want.free, $signed(i_res_data[FREE_W-1:0]));
                    end
                end
            end
        end
        o_pending      <= outcomes.size();
        o_fail_count   <= fail_cnt;
        o_result_count <= result_cnt;
        o_full_count   <= full_cnt;
        o_miss_count   <= miss_cnt;
    end

endmodule

/* tb/sv/memory_residency_table_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// memory_residency_table_unit_tb
// Stimulus and verdict for the memory residency table unit.
// ----------------------------------------------------------------------------
// Drives a directed set of requests covering empty tables, unknown kinds,
// duplicate ids and extreme fields, then random phases that fill and drain
// both tables under several total_memory settings and idle patterns,
// including a long receiver hold-off. The checker predicts and compares.
// ----------------------------------------------------------------------------
module memory_residency_table_unit_tb;
    import mrt_pkg::*;

    localparam int RESET_CYCLES = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 48;
    localparam int HOLD_PHASE   = 3;
    localparam int HOLD_CYCLES  = 400;
    localparam int POOL_SIZE    = 8;
    localparam int POOL_IW      = $clog2(POOL_SIZE);
    localparam logic [ADDR_W-1:0] TOTAL_ADDR     = {REG_TOTAL_MEMORY, 2'b00};
    localparam logic [REQ_W-1:0]  REQ_BOGUS_LO   = REQ_FIND + 1'b1;
    localparam logic [REQ_W-1:0]  REQ_BOGUS_HI   = {REQ_W{1'b1}};

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic [31:0]       s_tdata   = '0;
    logic [3:0]        s_tuser   = '0;
    logic              s_tready;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [23:0]       m_tdata;
    logic [1:0]        m_tuser;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int pending;
    int fail_count;
    int result_count;
    int full_count;
    int miss_count;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int phase_id      = 0;
    int hold_left     = 0;
    logic hold_done   = 1'b0;
    int cycle_cnt     = 0;
    int sent_count    = 0;
    int setting_count = 0;
    logic [ID_W-1:0] id_pool [POOL_SIZE];

    always #5 clk = ~clk;

    memory_residency_table_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_pready        (pready)
    );

    mrt_residency_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_req_valid    (s_tvalid),
        .i_req_ready    (s_tready),
        .i_req_data     (s_tdata),
        .i_req_user     (s_tuser),
        .i_res_valid    (m_tvalid),
        .i_res_ready    (m_tready),
        .i_res_data     (m_tdata),
        .i_res_user     (m_tuser),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_result_count (result_count),
        .o_full_count   (full_count),
        .o_miss_count   (miss_count)
    );

    // result side: random stalls, one long hold-off while requests keep coming
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (phase_id == HOLD_PHASE && !hold_done) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("cycle limit reached with %0d results outstanding", pending);
            $display("memory_residency_table_unit_tb failed");
            $finish;
        end
    end

    task automatic issue_request(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id,
                                 input logic [SIZE_W-1:0] sz, input logic in_mem);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(32 - ID_W - SIZE_W){1'b0}}, sz, id};
        s_tuser  <= {in_mem, kind};
        do @(posedge clk); while (!s_tready);
        sent_count++;
    endtask

    // sender pauses until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_total(input logic [TOTAL_W-1:0] total);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TOTAL_ADDR;
        pwdata  <= {{(DATA_W - TOTAL_W){1'b0}}, total};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        setting_count++;
    endtask

    task automatic refresh_pool();
        int k;
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++) id_pool[k] = ID_W'($urandom_range(16'hFFFF));
    endtask

    task automatic run_random(input int n, input int grow_pct);
        int i;
        int r;
        logic [REQ_W-1:0]  kind;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] sz;
        for (i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 3)
                kind = REQ_W'($urandom_range(REQ_BOGUS_HI, REQ_BOGUS_LO));
            else if (r < 3 + grow_pct)
                kind = $urandom_range(1) ? REQ_LOAD : REQ_ADD_DISK;
            else if (r < 3 + grow_pct + (97 - grow_pct) * 2 / 3)
                kind = $urandom_range(1) ? REQ_EVICT : REQ_RM_DISK;
            else
                kind = REQ_FIND;
            if ($urandom_range(99) < 80)
                id = id_pool[POOL_IW'($urandom_range(POOL_SIZE - 1))];
            else id = ID_W'($urandom_range(16'hFFFF));
            r = $urandom_range(19);
            if (r == 0) sz = '0;
            else if (r == 1) sz = '1;
            else sz = SIZE_W'($urandom_range({SIZE_W{1'b1}}));
            issue_request(kind, id, sz, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty tables, unknown kinds, duplicates, extreme fields
        issue_request(REQ_FIND,     16'h0000, '0, 1'b1);
        issue_request(REQ_FIND,     16'h0000, '0, 1'b0);
        issue_request(REQ_EVICT,    16'h0000, '0, 1'b0);
        issue_request(REQ_RM_DISK,  16'h0000, '0, 1'b0);
        issue_request(REQ_BOGUS_LO, 16'hFFFF, '1, 1'b1);
        issue_request(REQ_BOGUS_LO + 1'b1, 16'h0000, '0, 1'b0);
        issue_request(REQ_BOGUS_HI, 16'hFFFF, '1, 1'b1);
        issue_request(REQ_LOAD,     16'hFFFF, '1, 1'b0);
        issue_request(REQ_LOAD,     16'h0000, '0, 1'b1);
        issue_request(REQ_LOAD,     16'hFFFF, 12'd1, 1'b0);
        issue_request(REQ_FIND,     16'hFFFF, '0, 1'b1);
        issue_request(REQ_EVICT,    16'hFFFF, '0, 1'b0);
        issue_request(REQ_FIND,     16'hFFFF, '0, 1'b1);
        issue_request(REQ_EVICT,    16'h0000, '0, 1'b0);
        issue_request(REQ_EVICT,    16'h1234, '0, 1'b0);
        issue_request(REQ_ADD_DISK, 16'hFFFF, '0, 1'b0);
        issue_request(REQ_ADD_DISK, 16'h0000, '0, 1'b0);
        issue_request(REQ_ADD_DISK, 16'hFFFF, '0, 1'b0);
        issue_request(REQ_FIND,     16'h0000, '0, 1'b0);
        issue_request(REQ_RM_DISK,  16'hFFFF, '0, 1'b0);
        issue_request(REQ_FIND,     16'hFFFF, '0, 1'b0);
        issue_request(REQ_RM_DISK,  16'h1234, '0, 1'b0);
        issue_request(REQ_FIND,     16'h0000, '0, 1'b1);
        drain();

        phase_id = 1;
        write_total(16'hFFFF);
        refresh_pool();
        run_random(200, 60);
        drain();

        phase_id      = 2;
        send_idle_pct = 61;
        write_total(16'h0000);
        refresh_pool();
        run_random(200, 45);
        drain();

        // counter reloaded while the memory table is occupied: evictions saturate
        phase_id      = HOLD_PHASE;
        send_idle_pct = 0;
        stall_pct     = 61;
        write_total(16'hFFFF);
        run_random(200, 25);
        drain();

        phase_id      = 4;
        send_idle_pct = 24;
        stall_pct     = 24;
        write_total(TOTAL_W'($urandom_range(16'hFFFF)));
        refresh_pool();
        run_random(200, 45);
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d requests under %0d total_memory settings plus the reset value.",
                 sent_count, setting_count);
        $display("%0d results checked: %0d table full, %0d not found or unknown.",
                 result_count, full_count, miss_count);
        if (fail_count == 0 && pending == 0)
            $display("memory_residency_table_unit_tb passed");
        else
            $display("memory_residency_table_unit_tb failed");
        $finish;
    end

endmodule

/* memory_residency_table_unit.f */
sv/mrt_pkg.sv
sv/mrt_ram.sv
sv/mrt_ctrl.sv
sv/memory_residency_table_unit.sv
tb/sv/mrt_residency_checker.sv
tb/sv/memory_residency_table_unit_tb.sv
